>>> rtl/sign_partition_dutch_flag_unit_macros.svh
// Assertion macros shared by the partition unit.
`ifndef SIGN_PARTITION_DUTCH_FLAG_UNIT_MACROS_SVH
`define SIGN_PARTITION_DUTCH_FLAG_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk outside reset.
`define SPDF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define SPDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/spdf_pkg.sv
package spdf_pkg;

    localparam int WORD_W           = 32;
    localparam int MAX_ELEMENTS_DEF = 64;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     final_item;
    } spdf_req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value_out;
        logic                     last_out;
        logic                     overflow;
    } spdf_res_t;

    // Flags travelling with an emission read, issued in the cycle before its data
    typedef struct packed {
        logic valid;
        logic last;
        logic overflow;
    } spdf_emit_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_EVAL,
        ST_SWAP_LO,
        ST_SWAP_HI,
        ST_EMIT,
        ST_DRAIN
    } spdf_state_t;

endpackage

>>> rtl/spdf_ram.sv
module spdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

>>> rtl/spdf_ctrl.sv
module spdf_ctrl #(
    parameter int MAX_ELEMENTS = spdf_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  spdf_pkg::spdf_req_t                req,
    output logic                               busy,
    output logic                               wr_en,
    output logic [$clog2(MAX_ELEMENTS)-1:0]    wr_addr,
    output logic [spdf_pkg::WORD_W-1:0]        wr_data,
    output logic [$clog2(MAX_ELEMENTS)-1:0]    rd_addr_a,
    output logic [$clog2(MAX_ELEMENTS)-1:0]    rd_addr_b,
    input  logic [spdf_pkg::WORD_W-1:0]        rd_data_a,
    input  logic [spdf_pkg::WORD_W-1:0]        rd_data_b,
    output spdf_pkg::spdf_emit_t               emit
);

    import spdf_pkg::*;

    localparam int PTR_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);

    spdf_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  lo_reg, lo_next;
    logic [PTR_W-1:0]  hi_reg, hi_next;
    logic [PTR_W-1:0]  idx_reg, idx_next;
    logic              ovf_reg, ovf_next;
    logic [WORD_W-1:0] lo_val_reg, lo_val_next;
    logic [WORD_W-1:0] hi_val_reg, hi_val_next;

    logic             accept;
    logic             full;
    logic [CNT_W-1:0] count_after;
    logic [CNT_W-1:0] count_last;
    logic             idx_is_last;
    logic             ptrs_met;
    logic             lo_neg;
    logic             hi_neg;

    assign accept      = start && (state_reg == ST_IDLE);
    assign full        = (count_reg >= CNT_MAX);
    assign count_after = full ? count_reg : count_reg + CNT_W'(1);
    assign count_last  = count_reg - CNT_W'(1);
    assign idx_is_last = (CNT_W'(idx_reg) == count_last);
    assign ptrs_met    = (lo_reg >= hi_reg);
    assign lo_neg      = lo_val_reg[WORD_W-1];
    assign hi_neg      = hi_val_reg[WORD_W-1];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.final_item)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:   state_next = ST_LOAD;
            ST_LOAD:    state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (ptrs_met)
                begin
                    state_next = ST_EMIT;
                end
                else if (lo_neg || !hi_neg)
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    state_next = ST_SWAP_LO;
                end
            end
            ST_SWAP_LO: state_next = ST_SWAP_HI;
            ST_SWAP_HI: state_next = ST_EVAL;
            ST_EMIT:
            begin
                if (idx_is_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:   state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy        = (state_reg != ST_IDLE);
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        idx_next    = idx_reg;
        ovf_next    = ovf_reg;
        lo_val_next = lo_val_reg;
        hi_val_next = hi_val_reg;
        wr_en       = 1'b0;
        wr_addr     = count_reg[PTR_W-1:0];
        wr_data     = req.value;
        rd_addr_a   = (state_reg == ST_EMIT) ? idx_reg : lo_reg;
        rd_addr_b   = hi_reg;
        emit        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_after;
                    end
                    if (req.final_item)
                    begin
                        lo_next = '0;
                        hi_next = PTR_W'(count_after - CNT_W'(1));
                    end
                end
            end
            ST_LOAD:
            begin
                lo_val_next = rd_data_a;
                hi_val_next = rd_data_b;
            end
            ST_EVAL:
            begin
                if (ptrs_met)
                begin
                    idx_next = '0;
                end
                else if (lo_neg)
                begin
                    lo_next = lo_reg + PTR_W'(1);
                end
                else if (!hi_neg)
                begin
                    hi_next = hi_reg - PTR_W'(1);
                end
            end
            ST_SWAP_LO:
            begin
                wr_en   = 1'b1;
                wr_addr = lo_reg;
                wr_data = hi_val_reg;
            end
            ST_SWAP_HI:
            begin
                // second half of the swap: exchange the cached words as well
                wr_en       = 1'b1;
                wr_addr     = hi_reg;
                wr_data     = lo_val_reg;
                lo_val_next = hi_val_reg;
                hi_val_next = lo_val_reg;
            end
            ST_EMIT:
            begin
                emit.valid    = 1'b1;
                emit.last     = idx_is_last;
                emit.overflow = ovf_reg;
                if (!idx_is_last)
                begin
                    idx_next = idx_reg + PTR_W'(1);
                end
            end
            ST_DRAIN:
            begin
                count_next = '0;
                lo_next    = '0;
                hi_next    = '0;
                ovf_next   = 1'b0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            idx_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            idx_reg   <= idx_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_val_reg <= lo_val_next;
        hi_val_reg <= hi_val_next;
    end

endmodule

>>> rtl/sign_partition_dutch_flag_unit.sv
// Channel   Handshake             Payload
// request   start / busy          req    (value, final_item)
// result    result_valid strobe   result (value_out, last_out, overflow)
//
// A request that is not final is stored and busy stays low; when the store is
// full it is dropped and overflow is set. A final request starts the partition:
// every pointer step passes through memory read, capture and evaluate, and each
// swap adds two writes through the single write port, then a second evaluate.
// Emission then reads one word a cycle: N results on consecutive cycles, each
// in the cycle after its read, and busy drops the cycle after the last.
// Reset clears count, pointers and overflow; the store needs no clearing.
module sign_partition_dutch_flag_unit #(
    parameter int MAX_ELEMENTS = spdf_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  spdf_pkg::spdf_req_t req,
    output logic                busy,
    output logic                result_valid,
    output spdf_pkg::spdf_res_t result
);

    import spdf_pkg::*;

    `include "sign_partition_dutch_flag_unit_macros.svh"

    localparam int PTR_W = $clog2(MAX_ELEMENTS);

    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [PTR_W-1:0]  rd_addr_a;
    logic [PTR_W-1:0]  rd_addr_b;
    logic [WORD_W-1:0] rd_data_a;
    logic [WORD_W-1:0] rd_data_b;
    spdf_emit_t        emit;
    spdf_emit_t        emit_reg;

    spdf_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .emit      (emit)
    );

    spdf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    // register the flags so they line up with the registered read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg <= '0;
        end
        else
        begin
            emit_reg <= emit;
        end
    end

    always_comb
    begin
        result_valid     = emit_reg.valid;
        result.value_out = rd_data_a;
        result.last_out  = emit_reg.last;
        result.overflow  = emit_reg.overflow;
    end

    `SPDF_ASSERT_NOW(a_result_while_busy, result_valid, busy, "result outside a busy window")
    `SPDF_ASSERT_NEXT(a_final_goes_busy, start && !busy && req.final_item, busy, "final request did not start the partition")
    `SPDF_ASSERT_NEXT(a_results_contiguous, result_valid && !result.last_out, result_valid, "gap inside a result list")
    `SPDF_ASSERT_NEXT(a_last_ends_list, result_valid && result.last_out, !result_valid, "result after the last of a list")

endmodule
